@@ hw/rtl/pse_pkg.sv @@
package pse_pkg;

  // byte sequencer phases in the back end
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_HEAD  = 3'd1,
    PH_IDLEN = 3'd2,
    PH_PIX   = 3'd3,
    PH_TAIL  = 3'd4
  } phase_t;

  // work item passed from front to back
  typedef struct packed {
    logic [23:0] rgb;
    logic        start;
    logic        row_start;
    logic        finish;
  } job_t;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [15:0] ADLER_MOD = 16'd65521;

  // stored block size; the block count logic relies on it being 2^16-1
  localparam logic [16:0] BLOCK_BYTES = 17'd65535;

  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [ADDR_W-1:0] REG_HEIGHT = 3'd1;

  // one byte through the crc
  function automatic logic [31:0] crc8(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/pse_front.sv @@
module pse_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_ready,
  input  logic [23:0]       pixel_rgb,
  input  logic [13:0]       eff_w,
  input  logic [13:0]       eff_h,
  output logic              busy,
  output logic              job_valid,
  input  logic              job_ready,
  output pse_pkg::job_t     job
);

  logic        started;
  logic [13:0] col;
  logic [13:0] row;
  logic        take;
  logic        eol;
  logic        eof;

  assign pixel_ready = job_ready;
  assign job_valid   = pixel_valid;
  assign take        = pixel_valid && job_ready;
  assign eol         = (col + 14'd1) >= eff_w;
  assign eof         = eol && ((row + 14'd1) >= eff_h);
  assign busy        = started;

  // classify the pixel
  always_comb begin
    job.rgb       = pixel_rgb;
    job.start     = !started;
    job.row_start = !started || (col == 14'd0);
    job.finish    = eof;
  end

  // raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      col     <= '0;
      row     <= '0;
    end else if (take) begin
      if (eof) begin
        started <= 1'b0;
        col     <= '0;
        row     <= '0;
      end else begin
        started <= 1'b1;
        if (eol) begin
          col <= '0;
          row <= row + 14'd1;
        end else begin
          col <= (started ? col : 14'd0) + 14'd1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/pse_queue.sv @@
module pse_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  pse_pkg::job_t in_job,
  output logic          out_valid,
  input  logic          out_ready,
  output pse_pkg::job_t out_job
);

  pse_pkg::job_t slot [2];
  logic [1:0] count;
  logic       wp;
  logic       rp;
  logic       push;
  logic       pop;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_job   = slot[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wp] <= in_job;
  end

endmodule

@@ hw/rtl/pse_back.sv @@
module pse_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  pse_pkg::job_t job,
  input  logic [13:0]   eff_w,
  input  logic [13:0]   eff_h,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          last_byte
);

  localparam logic [16:0] BLK = pse_pkg::BLOCK_BYTES;

  // sequence phase within a job: header, idat length and type, pixel bytes, trailer
  pse_pkg::phase_t phase;
  logic [5:0]  idx;
  logic [1:0]  resume;
  pse_pkg::job_t cur;
  logic [31:0] crc;
  logic [15:0] s1;
  logic [15:0] s2;
  logic [31:0] raw_left;
  logic [16:0] blk_left;
  logic [16:0] w3p1;
  logic [31:0] raw_total;
  logic [15:0] blk_q;
  logic [16:0] blk_r;
  logic [15:0] blk_cnt;
  logic [31:0] idat_len;
  logic        step;

  // output register
  logic        ov;
  logic [7:0]  ob;
  logic        ol;

  logic        have;
  logic [7:0]  b;
  logic        b_crc;
  logic        b_raw;
  logic        b_last;
  logic        crc_reset;
  logic        done_job;
  logic [2:0]  pix_i;
  logic [16:0] n;

  assign out_valid = ov;
  assign out_byte  = ob;
  assign last_byte = ol;
  assign step      = have && (!ov || out_ready);
  assign job_ready = (phase == pse_pkg::PH_IDLE);

  // block length for the next stored block header
  assign n = (raw_left > {15'd0, BLK}) ? BLK : raw_left[16:0];

  // byte generator
  always_comb begin
    have = 1'b0; b = 8'd0; b_crc = 1'b0; b_raw = 1'b0; b_last = 1'b0;
    crc_reset = 1'b0; done_job = 1'b0; pix_i = idx[2:0];
    unique case (phase)
      pse_pkg::PH_IDLE: ;
      pse_pkg::PH_HEAD: begin
        have = 1'b1;
        case (idx)
          6'd0: b = 8'h89; 6'd1: b = 8'h50; 6'd2: b = 8'h4e; 6'd3: b = 8'h47;
          6'd4: b = 8'h0d; 6'd5: b = 8'h0a; 6'd6: b = 8'h1a; 6'd7: b = 8'h0a;
          6'd8, 6'd9, 6'd10: b = 8'h00; 6'd11: b = 8'd13;
          6'd12: begin b = 8'h49; crc_reset = 1'b1; end
          6'd13: begin b = 8'h48; b_crc = 1'b1; end
          6'd14: begin b = 8'h44; b_crc = 1'b1; end
          6'd15: begin b = 8'h52; b_crc = 1'b1; end
          6'd16, 6'd17: begin b = 8'h00; b_crc = 1'b1; end
          6'd18: begin b = {2'd0, eff_w[13:8]}; b_crc = 1'b1; end
          6'd19: begin b = eff_w[7:0]; b_crc = 1'b1; end
          6'd20, 6'd21: begin b = 8'h00; b_crc = 1'b1; end
          6'd22: begin b = {2'd0, eff_h[13:8]}; b_crc = 1'b1; end
          6'd23: begin b = eff_h[7:0]; b_crc = 1'b1; end
          6'd24: begin b = 8'd8; b_crc = 1'b1; end
          6'd25: begin b = 8'd2; b_crc = 1'b1; end
          6'd26, 6'd27, 6'd28: begin b = 8'd0; b_crc = 1'b1; end
          6'd29: b = ~crc[31:24]; 6'd30: b = ~crc[23:16];
          6'd31: b = ~crc[15:8];  6'd32: b = ~crc[7:0];
          default: have = 1'b0;
        endcase
      end
      pse_pkg::PH_IDLEN: begin
        have = 1'b1;
        case (idx)
          6'd0: b = idat_len[31:24]; 6'd1: b = idat_len[23:16];
          6'd2: b = idat_len[15:8];  6'd3: b = idat_len[7:0];
          6'd4: begin b = 8'h49; crc_reset = 1'b1; end
          6'd5: begin b = 8'h44; b_crc = 1'b1; end
          6'd6: begin b = 8'h41; b_crc = 1'b1; end
          6'd7: begin b = 8'h54; b_crc = 1'b1; end
          6'd8: begin b = 8'h78; b_crc = 1'b1; end
          6'd9: begin b = 8'h01; b_crc = 1'b1; end
          default: have = 1'b0;
        endcase
      end
      pse_pkg::PH_PIX: begin
        have = 1'b1; b_crc = 1'b1;
        // idx: 0 filter, 1..3 colours; idx[5] set means block header byte
        if (idx[5]) begin
          case (idx[2:0])
            3'd0: b = {7'd0, raw_left == {15'd0, n}};
            3'd1: b = n[7:0];
            3'd2: b = n[15:8];
            3'd3: b = ~n[7:0];
            default: b = ~n[15:8];
          endcase
        end else begin
          b_raw = 1'b1;
          case (pix_i)
            3'd0: b = 8'h00;
            3'd1: b = cur.rgb[23:16];
            3'd2: b = cur.rgb[15:8];
            default: b = cur.rgb[7:0];
          endcase
          b_last = 1'b0;
        end
      end
      pse_pkg::PH_TAIL: begin
        have = 1'b1;
        case (idx)
          6'd0: begin b = s2[15:8]; b_crc = 1'b1; end
          6'd1: begin b = s2[7:0];  b_crc = 1'b1; end
          6'd2: begin b = s1[15:8]; b_crc = 1'b1; end
          6'd3: begin b = s1[7:0];  b_crc = 1'b1; end
          6'd4: b = ~crc[31:24]; 6'd5: b = ~crc[23:16];
          6'd6: b = ~crc[15:8];  6'd7: b = ~crc[7:0];
          6'd8, 6'd9, 6'd10, 6'd11: b = 8'h00;
          6'd12: begin b = 8'h49; crc_reset = 1'b1; end
          6'd13: begin b = 8'h45; b_crc = 1'b1; end
          6'd14: begin b = 8'h4e; b_crc = 1'b1; end
          6'd15: begin b = 8'h44; b_crc = 1'b1; end
          6'd16: b = ~crc[31:24]; 6'd17: b = ~crc[23:16];
          6'd18: b = ~crc[15:8];
          6'd19: begin b = ~crc[7:0]; b_last = 1'b1; end
          default: have = 1'b0;
        endcase
      end
      default: ;
    endcase
  end

  logic        take_job;
  logic [16:0] s1_sum;
  logic [16:0] s1_mod;
  logic [16:0] s2_sum;
  logic [15:0] s2_mod;
  logic        pix_end;

  assign take_job = job_valid && (phase == pse_pkg::PH_IDLE);
  assign s1_sum   = {1'b0, s1} + {9'd0, b};
  assign s1_mod   = (s1_sum >= {1'b0, pse_pkg::ADLER_MOD}) ?
                    s1_sum - {1'b0, pse_pkg::ADLER_MOD} : s1_sum;
  assign s2_sum   = {1'b0, s2} + s1_mod;
  assign s2_mod   = (s2_sum >= {1'b0, pse_pkg::ADLER_MOD}) ?
                    16'(s2_sum - {1'b0, pse_pkg::ADLER_MOD}) : s2_sum[15:0];
  assign pix_end  = !idx[5] && (idx[2:0] == 3'd3);

  // sequencer, crc, adler and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= pse_pkg::PH_IDLE;
      idx      <= '0;
      resume   <= '0;
      crc      <= '1;
      s1       <= 16'd1;
      s2       <= 16'd0;
      raw_left <= '0;
      blk_left <= '0;
      ov       <= 1'b0;
    end else begin
      if (ov && out_ready) ov <= 1'b0;
      if (take_job) begin
        cur <= job;
        if (job.start) begin
          phase    <= pse_pkg::PH_HEAD;
          idx      <= '0;
          resume   <= 2'd0;
          s1       <= 16'd1;
          s2       <= 16'd0;
          raw_left <= raw_total;
          blk_left <= '0;
        end else begin
          phase  <= pse_pkg::PH_PIX;
          resume <= {1'b0, !job.row_start};
          if (blk_left == 17'd0) idx <= 6'd32;
          else idx <= {5'd0, !job.row_start};
        end
      end else if (step) begin
        ov <= 1'b1;
        ob <= b;
        ol <= b_last;
        if (crc_reset) crc <= pse_pkg::crc8('1, b);
        else if (b_crc) crc <= pse_pkg::crc8(crc, b);
        if (b_raw) begin
          s1 <= s1_mod[15:0];
          s2 <= s2_mod;
          raw_left <= raw_left - 32'd1;
          blk_left <= blk_left - 17'd1;
        end
        unique case (phase)
          pse_pkg::PH_HEAD: if (idx == 6'd32) begin
                              phase <= pse_pkg::PH_IDLEN; idx <= '0;
                            end else idx <= idx + 6'd1;
          pse_pkg::PH_IDLEN: if (idx == 6'd9) begin
                               phase <= pse_pkg::PH_PIX;
                               idx   <= (blk_left == 17'd0) ? 6'd32 : 6'd0;
                             end else idx <= idx + 6'd1;
          pse_pkg::PH_PIX: begin
            if (idx[5]) begin
              if (idx[2:0] == 3'd4) begin
                blk_left <= n;
                idx      <= {4'd0, resume};
              end else idx <= idx + 6'd1;
            end else if (pix_end) begin
              if (cur.finish) begin phase <= pse_pkg::PH_TAIL; idx <= '0; end
              else phase <= pse_pkg::PH_IDLE;
            end else if (blk_left == 17'd1) begin
              // block runs out inside the pixel: header, then carry on
              idx    <= 6'd32;
              resume <= idx[1:0] + 2'd1;
            end else idx <= idx + 6'd1;
          end
          pse_pkg::PH_TAIL: if (idx == 6'd19) phase <= pse_pkg::PH_IDLE;
                            else idx <= idx + 6'd1;
          default: ;
        endcase
      end
    end
  end

  // stored block count: x / 65535 via x = q * 65535 + (q + low half)
  // raw_total stays below 2^28, so one correction step is enough
  assign blk_q = raw_total[31:16];
  assign blk_r = {1'b0, raw_total[15:0]} + {1'b0, blk_q};
  always_comb begin
    if (blk_r >= BLK) blk_cnt = blk_q + 16'd1 + {15'd0, (blk_r != BLK)};
    else blk_cnt = blk_q + {15'd0, (blk_r != 17'd0)};
  end

  // idat length, follows the configuration
  assign w3p1 = 17'(eff_w) * 17'd3 + 17'd1;
  always_ff @(posedge clk) begin
    raw_total <= {15'd0, w3p1} * {18'd0, eff_h};
    idat_len  <= raw_total + 32'd6 + {14'd0, blk_cnt, 2'b00} + {16'd0, blk_cnt};
  end

  assign_check: assert property (@(posedge clk) disable iff (rst)
    (ov && !out_ready) |=> (ov && $stable(ob)))
    else $error("output changed while stalled");

  last_check: assert property (@(posedge clk) disable iff (rst)
    (ov && ol && out_ready) |=> (phase == pse_pkg::PH_IDLE || phase == pse_pkg::PH_HEAD))
    else $error("bytes after last");

  blk_check: assert property (@(posedge clk) disable iff (rst)
    (step && b_raw) |-> (blk_left != 17'd0))
    else $error("raw byte outside a stored block");

endmodule

@@ hw/rtl/png_stored_rgb_encoder_core.sv @@
// png encoder, stored deflate, rgb8
// bytes: a pixel passes the queue and the back end to the output register;
//   first pixel of a file gives 52 bytes, others 3..9, the last of a file adds 20
// throughput: one output byte per cycle while out_ready is high; each pixel costs
//   a front-to-back hand-over in the byte sequencer, during which no byte is sent
// reset: synchronous, active high; clears all control state, width 320, height 224
module png_stored_rgb_encoder_core #(
  parameter int MAX_WIDTH   = 4096,
  parameter int MAX_HEIGHT  = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        pixel_valid,
  output logic        pixel_ready,
  input  logic [23:0] pixel_rgb,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_byte
);

  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [13:0] eff_w;
  logic [13:0] eff_h;
  logic        front_busy;
  logic        fq_valid, fq_ready, qb_valid, qb_ready;
  pse_pkg::job_t fq_job, qb_job;

  assign pready = 1'b1;

  // clamp configuration
  always_comb begin
    eff_w = {1'b0, image_width};
    if (eff_w < 14'd2) eff_w = 14'd2;
    if (int'(eff_w) > MAX_WIDTH) eff_w = 14'(MAX_WIDTH);
    eff_h = {1'b0, image_height};
    if (eff_h < 14'd1) eff_h = 14'd1;
    if (int'(eff_h) > MAX_HEIGHT) eff_h = 14'(MAX_HEIGHT);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd320;
      image_height <= 13'd224;
    end else if (psel && penable && pwrite && !front_busy) begin
      if (paddr == {pse_pkg::REG_WIDTH[0], 2'b00}) image_width <= pwdata[12:0];
      else if (paddr == {pse_pkg::REG_HEIGHT[0], 2'b00}) image_height <= pwdata[12:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr == {pse_pkg::REG_WIDTH[0], 2'b00}) prdata = {19'd0, image_width};
    else if (paddr == {pse_pkg::REG_HEIGHT[0], 2'b00}) prdata = {19'd0, image_height};
  end

  pse_front u_front (
    .clk, .rst, .pixel_valid, .pixel_ready, .pixel_rgb, .eff_w, .eff_h,
    .busy(front_busy), .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  pse_queue u_queue (
    .clk, .rst, .in_valid(fq_valid), .in_ready(fq_ready), .in_job(fq_job),
    .out_valid(qb_valid), .out_ready(qb_ready), .out_job(qb_job)
  );

  pse_back u_back (
    .clk, .rst, .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
    .eff_w, .eff_h, .out_valid, .out_ready, .out_byte, .last_byte
  );

  cfg_quiet: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && front_busy) |=>
      ($stable(image_width) && $stable(image_height)))
    else $error("configuration changed during a file");

  pready_check: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule
